// File: hw/rtl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants of the Unicode to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  typedef enum logic [2:0] {
    MODE_UTF8    = 3'd0,
    MODE_U16BE   = 3'd1,
    MODE_U16LE   = 3'd2,
    MODE_U4BE    = 3'd3,
    MODE_U4LE    = 3'd4,
    MODE_U4_2143 = 3'd5,
    MODE_U4_3412 = 3'd6,
    MODE_BYTE    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DATA     = 2'd0,
    STAT_UNPAIRED = 2'd1,
    STAT_END      = 2'd2
  } status_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNIFF = 2'd1;

  localparam int unsigned MAX_RES   = 6;
  localparam int unsigned RES_CNT_W = 3;

  typedef struct packed {
    status_e    stat;
    logic [7:0] data;
  } tok_t;

  typedef tok_t [MAX_RES-1:0] tok_list_t;

  typedef logic [3:0][7:0] held_t;

  typedef struct packed {
    logic [1:0]  held_cnt;
    mode_e       mode;
    logic        sniff;
    logic [10:0] pend;
    logic        stop;
  } state_t;

endpackage

// File: hw/rtl/u2u8_step.sv
// ----------------------------------------------------------------------------
// u2u8_step
// Next-state and result logic for one input byte: mark detection, code unit
// assembly, surrogate joining and UTF-8 encoding.
// ----------------------------------------------------------------------------
module u2u8_step (
  input  u2u8_pkg::state_t                  state_i,
  input  u2u8_pkg::held_t                   held_i,
  input  logic [7:0]                        byte_i,
  input  logic                              start_i,
  input  u2u8_pkg::mode_e                   cfg_mode_i,
  input  logic                              cfg_sniff_i,
  output u2u8_pkg::state_t                  state_o,
  output u2u8_pkg::held_t                   held_o,
  output u2u8_pkg::tok_list_t               toks_o,
  output logic [u2u8_pkg::RES_CNT_W-1:0]    cnt_o
);

  localparam logic [15:0] BOM_BE      = 16'hFEFF;
  localparam logic [15:0] BOM_LE      = 16'hFFFE;
  localparam logic [15:0] BOM_U8_HEAD = 16'hEFBB;
  localparam logic [7:0]  BOM_U8_TAIL = 8'hBF;

  typedef struct packed {
    logic [2:0]      n;
    logic [5:0][7:0] b;
  } enc_t;

  typedef struct packed {
    u2u8_pkg::tok_list_t               t;
    logic [u2u8_pkg::RES_CNT_W-1:0]    c;
  } tl_t;

  function automatic enc_t utf8_enc(input logic [31:0] cp);
    enc_t e;
    e = '0;
    if (cp < 32'h80) begin
      e.n = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      e.n = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 32'h10000) begin
      e.n = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else if (cp < 32'h200000) begin
      e.n = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end else if (cp < 32'h4000000) begin
      e.n = 3'd5;
      e.b[0] = {6'b111110, cp[25:24]};
      e.b[1] = {2'b10, cp[23:18]};
      e.b[2] = {2'b10, cp[17:12]};
      e.b[3] = {2'b10, cp[11:6]};
      e.b[4] = {2'b10, cp[5:0]};
    end else if (cp < 32'h80000000) begin
      e.n = 3'd6;
      e.b[0] = {7'b1111110, cp[30]};
      e.b[1] = {2'b10, cp[29:24]};
      e.b[2] = {2'b10, cp[23:18]};
      e.b[3] = {2'b10, cp[17:12]};
      e.b[4] = {2'b10, cp[11:6]};
      e.b[5] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  function automatic tl_t push(input tl_t l, input u2u8_pkg::status_e s,
                               input logic [7:0] d);
    tl_t r;
    r = l;
    if (l.c < u2u8_pkg::RES_CNT_W'(u2u8_pkg::MAX_RES)) begin
      r.t[l.c].stat = s;
      r.t[l.c].data = d;
      r.c = l.c + 3'd1;
    end
    return r;
  endfunction

  u2u8_pkg::mode_e md;
  u2u8_pkg::mode_e hit_mode;
  logic            snf;
  logic [10:0]     pnd;
  logic            stp;
  logic [1:0]      hc;
  logic [2:0]      n;
  logic [2:0]      k;
  u2u8_pkg::held_t h;
  u2u8_pkg::held_t fb;
  u2u8_pkg::held_t a;
  u2u8_pkg::held_t held_d;
  logic [2:0]      fn;
  logic [2:0]      tot;
  logic [15:0]     w;
  logic [15:0]     v16;
  logic [15:0]     u;
  logic [31:0]     v;
  logic            more;
  logic            hit;
  logic            resolve;
  logic            feed;
  logic            lo_sur;
  logic            hi_sur;
  logic            e_err;
  logic            e_end;
  logic            e_enc;
  logic [31:0]     e_cp;
  enc_t            enc;
  tl_t             tl;

  always_comb begin
    md = state_i.mode;
    snf = state_i.sniff;
    pnd = state_i.pend;
    stp = state_i.stop;
    hc = state_i.held_cnt;
    held_d = held_i;
    if (start_i) begin
      md = cfg_mode_i;
      snf = cfg_sniff_i;
      pnd = '0;
      stp = 1'b0;
      hc = '0;
    end

    tl = '0;
    h = held_i;
    h[hc] = byte_i;
    n = {1'b0, hc} + 3'd1;
    w = {h[0], h[1]};
    v16 = {h[2], h[3]};
    more = 1'b0;
    hit = 1'b0;
    hit_mode = md;
    k = '0;
    fb = '0;
    fb[0] = byte_i;
    fn = 3'd1;
    resolve = 1'b0;
    feed = !stp;
    a = '0;
    tot = '0;
    u = '0;
    v = '0;
    lo_sur = 1'b0;
    hi_sur = 1'b0;
    e_err = 1'b0;
    e_end = 1'b0;
    e_enc = 1'b0;
    e_cp = '0;
    enc = '0;

    if (!stp && snf) begin
      case (hc)
        2'd0: begin
          more = (byte_i == 8'h00) || (byte_i == 8'hFF) || (byte_i == 8'hFE) ||
                 (byte_i == 8'hEF);
        end
        2'd1: begin
          more = (w == 16'h0000) || (w == BOM_LE) || (w == BOM_BE) || (w == BOM_U8_HEAD);
        end
        2'd2: begin
          if (w == 16'h0000) begin
            more = (h[2] == 8'hFE) || (h[2] == 8'hFF);
          end else if (w == BOM_LE) begin
            if (h[2] == 8'h00) begin
              more = 1'b1;
            end else begin
              hit = 1'b1;
              hit_mode = u2u8_pkg::MODE_U16LE;
              k = 3'd2;
            end
          end else if (w == BOM_BE) begin
            if (h[2] == 8'h00) begin
              more = 1'b1;
            end else begin
              hit = 1'b1;
              hit_mode = u2u8_pkg::MODE_U16BE;
              k = 3'd2;
            end
          end else if (h[2] == BOM_U8_TAIL) begin
            hit = 1'b1;
            hit_mode = u2u8_pkg::MODE_UTF8;
            k = 3'd3;
          end
        end
        default: begin
          if (w == 16'h0000) begin
            if (v16 == BOM_BE) begin
              hit = 1'b1;
              hit_mode = u2u8_pkg::MODE_U4BE;
              k = 3'd4;
            end else if (v16 == BOM_LE) begin
              hit = 1'b1;
              hit_mode = u2u8_pkg::MODE_U4_2143;
              k = 3'd4;
            end
          end else if (w == BOM_LE) begin
            hit = 1'b1;
            if (h[3] == 8'h00) begin
              hit_mode = u2u8_pkg::MODE_U4LE;
              k = 3'd4;
            end else begin
              hit_mode = u2u8_pkg::MODE_U16LE;
              k = 3'd2;
            end
          end else begin
            hit = 1'b1;
            if (h[3] == 8'h00) begin
              hit_mode = u2u8_pkg::MODE_U4_3412;
              k = 3'd4;
            end else begin
              hit_mode = u2u8_pkg::MODE_U16BE;
              k = 3'd2;
            end
          end
        end
      endcase

      if (more) begin
        held_d = h;
        hc = hc + 2'd1;
        feed = 1'b0;
      end else begin
        snf = 1'b0;
        hc = '0;
        resolve = 1'b1;
        if (hit) begin
          md = hit_mode;
        end
        case (k)
          3'd2:    fb = {16'h0000, h[3], h[2]};
          3'd3:    fb = {24'h000000, h[3]};
          3'd4:    fb = '0;
          default: fb = h;
        endcase
        fn = n - k;
      end
    end

    if (feed) begin
      case (md)
        u2u8_pkg::MODE_UTF8, u2u8_pkg::MODE_BYTE: begin
          for (int i = 0; i < 4; i++) begin
            if ((3'(i) < fn) && !stp) begin
              if (fb[i] == 8'h00) begin
                tl = push(tl, u2u8_pkg::STAT_END, 8'h00);
                stp = 1'b1;
              end else if (md == u2u8_pkg::MODE_UTF8 || !fb[i][7]) begin
                tl = push(tl, u2u8_pkg::STAT_DATA, fb[i]);
              end else begin
                tl = push(tl, u2u8_pkg::STAT_DATA, {6'b110000, fb[i][7:6]});
                tl = push(tl, u2u8_pkg::STAT_DATA, {2'b10, fb[i][5:0]});
              end
            end
          end
        end
        default: begin
          if (resolve) begin
            a = fb;
            tot = fn;
          end else begin
            a = held_i;
            a[hc] = byte_i;
            tot = {1'b0, hc} + 3'd1;
          end
          if (md == u2u8_pkg::MODE_U16BE || md == u2u8_pkg::MODE_U16LE) begin
            if (tot < 3'd2) begin
              held_d = a;
              hc = tot[1:0];
            end else begin
              u = (md == u2u8_pkg::MODE_U16BE) ? {a[0], a[1]} : {a[1], a[0]};
              held_d[0] = a[2];
              held_d[1] = a[3];
              hc = 2'(tot - 3'd2);
              lo_sur = (u[15:10] == 6'b110111);
              hi_sur = (u[15:10] == 6'b110110);
              if (pnd[10] && lo_sur) begin
                e_enc = 1'b1;
                e_cp = 32'(21'h10000 + {1'b0, pnd[9:0], u[9:0]});
                pnd = '0;
              end else begin
                if (pnd[10]) begin
                  e_err = 1'b1;
                  pnd = '0;
                end
                if (u == 16'h0000 || lo_sur) begin
                  e_end = 1'b1;
                end else if (hi_sur) begin
                  pnd = {1'b1, u[9:0]};
                end else begin
                  e_enc = 1'b1;
                  e_cp = {16'h0000, u};
                end
              end
            end
          end else begin
            if (tot < 3'd4) begin
              held_d = a;
              hc = tot[1:0];
            end else begin
              hc = '0;
              case (md)
                u2u8_pkg::MODE_U4BE:    v = {a[0], a[1], a[2], a[3]};
                u2u8_pkg::MODE_U4LE:    v = {a[3], a[2], a[1], a[0]};
                u2u8_pkg::MODE_U4_2143: v = {a[1], a[0], a[3], a[2]};
                default:                v = {a[2], a[3], a[0], a[1]};
              endcase
              e_end = (v == 32'h0);
              e_enc = (v != 32'h0);
              e_cp = v;
            end
          end
        end
      endcase

      if (e_err) begin
        tl = push(tl, u2u8_pkg::STAT_UNPAIRED, 8'h00);
      end
      if (e_end) begin
        tl = push(tl, u2u8_pkg::STAT_END, 8'h00);
        stp = 1'b1;
      end
      if (e_enc) begin
        enc = utf8_enc(e_cp);
        for (int j = 0; j < 6; j++) begin
          if (3'(j) < enc.n) begin
            tl = push(tl, u2u8_pkg::STAT_DATA, enc.b[j]);
          end
        end
      end
    end

    if (stp) begin
      hc = '0;
      pnd = '0;
    end

    state_o.held_cnt = hc;
    state_o.mode = md;
    state_o.sniff = snf;
    state_o.pend = pnd;
    state_o.stop = stp;
    held_o = held_d;
    toks_o = tl.t;
    cnt_o = tl.c;
  end

endmodule

// File: hw/rtl/unicode_to_utf8_transcoder_top.sv
// ----------------------------------------------------------------------------
// unicode_to_utf8_transcoder_top
// Byte-stream transcoder from UTF-16, UCS-4, single-byte or UTF-8 text to
// UTF-8, with optional byte-order-mark detection at stream start.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one raw byte per item with
//   stream_start_i set on the first byte of a new text stream. Output channel
//   (out_valid_o / out_stall_i) gives zero to six items per input item, the
//   last one flagged by last_of_run_o; status_o tells data bytes apart from
//   an unpaired high surrogate and from end of string.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect on
//   the next stream start: index 0 is the encoding mode, index 1 enables
//   byte-order-mark detection.
//   Path: input register, step logic, result buffer. An item with results
//   leaves the input register only when the single result buffer is empty
//   or sending its last result; items with no results never wait. The
//   buffer sends one result per cycle while out_stall_i is low.
//   Reset: empties both stages, sets UTF-8 mode with detection enabled.
//   Receiver stall: the current result holds; the input register keeps one
//   more item, and in_stall_o rises while that item has results to write.
// ----------------------------------------------------------------------------
module unicode_to_utf8_transcoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         in_byte_i,
  input  logic                               stream_start_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               last_of_run_o,
  output logic [1:0]                         status_o,
  input  logic                               cfg_we_i,
  input  logic [u2u8_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [u2u8_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  u2u8_pkg::mode_e     cfg_mode_q;
  logic                cfg_sniff_q;

  logic                inq_vld_q;
  logic [7:0]          inq_byte_q;
  logic                inq_start_q;

  u2u8_pkg::state_t    state_q;
  u2u8_pkg::state_t    state_d;
  u2u8_pkg::held_t     held_q;
  u2u8_pkg::held_t     held_d;

  u2u8_pkg::tok_list_t step_toks;
  logic [u2u8_pkg::RES_CNT_W-1:0] step_cnt;

  u2u8_pkg::tok_list_t bun_tok_q;
  logic                bun_vld_q;
  logic [u2u8_pkg::RES_CNT_W-1:0] bun_idx_q;
  logic [u2u8_pkg::RES_CNT_W-1:0] bun_lst_q;

  logic                in_acc;
  logic                out_acc;
  logic                bun_last;
  logic                bun_free;
  logic                adv;

  u2u8_step u_step (
    .state_i     (state_q),
    .held_i      (held_q),
    .byte_i      (inq_byte_q),
    .start_i     (inq_start_q),
    .cfg_mode_i  (cfg_mode_q),
    .cfg_sniff_i (cfg_sniff_q),
    .state_o     (state_d),
    .held_o      (held_d),
    .toks_o      (step_toks),
    .cnt_o       (step_cnt)
  );

  assign out_acc    = bun_vld_q && !out_stall_i;
  assign bun_last   = (bun_idx_q == bun_lst_q);
  assign bun_free   = !bun_vld_q || (out_acc && bun_last);
  assign adv        = inq_vld_q && ((step_cnt == '0) || bun_free);
  assign in_stall_o = inq_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o   = bun_vld_q;
  assign out_byte_o    = bun_tok_q[bun_idx_q].data;
  assign status_o      = bun_tok_q[bun_idx_q].stat;
  assign last_of_run_o = bun_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q  <= u2u8_pkg::MODE_UTF8;
      cfg_sniff_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        u2u8_pkg::CFG_MODE:  cfg_mode_q  <= u2u8_pkg::mode_e'(cfg_wdata_i);
        u2u8_pkg::CFG_SNIFF: cfg_sniff_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_vld_q <= 1'b0;
    end else if (in_acc) begin
      inq_vld_q <= 1'b1;
    end else if (adv) begin
      inq_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      inq_byte_q  <= in_byte_i;
      inq_start_q <= stream_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.held_cnt <= '0;
      state_q.mode     <= u2u8_pkg::MODE_UTF8;
      state_q.sniff    <= 1'b1;
      state_q.pend     <= '0;
      state_q.stop     <= 1'b0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_vld_q <= 1'b0;
      bun_idx_q <= '0;
      bun_lst_q <= '0;
    end else if (adv && (step_cnt != '0)) begin
      bun_vld_q <= 1'b1;
      bun_idx_q <= '0;
      bun_lst_q <= step_cnt - 3'd1;
    end else if (out_acc) begin
      if (bun_last) begin
        bun_vld_q <= 1'b0;
      end else begin
        bun_idx_q <= bun_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (step_cnt != '0)) begin
      bun_tok_q <= step_toks;
    end
  end

endmodule

// File: hw/rtl/u2u8_chk.sv
// ----------------------------------------------------------------------------
// u2u8_chk
// Port-level checks of the transcoder output channel.
// ----------------------------------------------------------------------------
module u2u8_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o,
  input logic [1:0] status_o
);

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_payload_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_byte_o) && $stable(status_o) && $stable(last_of_run_o))
    else $error("output item changed while stalled");

  a_flag_zero_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != u2u8_pkg::STAT_DATA) |-> (out_byte_o == 8'h00))
    else $error("status item carries a nonzero byte");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == u2u8_pkg::STAT_END) |-> last_of_run_o)
    else $error("end of string not last of its run");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind unicode_to_utf8_transcoder_top u2u8_chk u_chk (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the Unicode to UTF-8 transcoder. Byte streams in every input
// encoding are sent through bursts, gaps and random receiver stalls. Some
// streams open with byte-order marks, and some carry noise or broken
// surrogate pairs. A behavioral transcoder predicts each output item, and
// every output item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_SETTINGS   = 12;
  localparam int PHASE_ITEMS    = 4;

  typedef struct {
    u2u8_pkg::tok_t tok;
    bit             last;
  } utf8_res_t;

  class utf8_predictor;
    u2u8_pkg::mode_e cfg_mode;
    bit              cfg_sniff;
    logic [7:0]      held [4];
    int              held_n;
    u2u8_pkg::mode_e act_mode;
    bit              sniffing;
    logic [10:0]     pend;
    bit              stopped;
    u2u8_pkg::tok_t  step_toks[$];
    utf8_res_t       utf8_q[$];
    int              errors;
    int              checked;

    function new();
      cfg_mode  = u2u8_pkg::MODE_UTF8;
      cfg_sniff = 1'b1;
      foreach (held[i]) held[i] = 8'h00;
      held_n    = 0;
      act_mode  = u2u8_pkg::MODE_UTF8;
      sniffing  = 1'b1;
      pend      = '0;
      stopped   = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(logic [u2u8_pkg::CFG_IDX_W-1:0] idx,
                          logic [u2u8_pkg::CFG_DATA_W-1:0] val);
      if (idx == u2u8_pkg::CFG_MODE) cfg_mode = u2u8_pkg::mode_e'(val);
      else if (idx == u2u8_pkg::CFG_SNIFF) cfg_sniff = val[0];
    endfunction

    function void emit(u2u8_pkg::status_e st, logic [7:0] b);
      u2u8_pkg::tok_t t;
      t.stat = st;
      t.data = (st == u2u8_pkg::STAT_DATA) ? b : 8'h00;
      if (step_toks.size() < u2u8_pkg::MAX_RES) step_toks.push_back(t);
    endfunction

    function void end_stream();
      emit(u2u8_pkg::STAT_END, 8'h00);
      stopped = 1'b1;
      held_n  = 0;
      pend    = '0;
    endfunction

    function void put_code_point(logic [31:0] cp);
      int n;
      logic [7:0] lead;
      if (cp < 32'h80) begin
        emit(u2u8_pkg::STAT_DATA, cp[7:0]);
        return;
      end
      if (cp < 32'h800) begin
        n = 2; lead = 8'hC0;
      end else if (cp < 32'h10000) begin
        n = 3; lead = 8'hE0;
      end else if (cp < 32'h200000) begin
        n = 4; lead = 8'hF0;
      end else if (cp < 32'h4000000) begin
        n = 5; lead = 8'hF8;
      end else if (cp < 32'h80000000) begin
        n = 6; lead = 8'hFC;
      end else begin
        return;
      end
      emit(u2u8_pkg::STAT_DATA, lead | 8'(cp >> (6 * (n - 1))));
      for (int i = n - 2; i >= 0; i--) begin
        emit(u2u8_pkg::STAT_DATA, 8'h80 | 8'((cp >> (6 * i)) & 32'h3F));
      end
    endfunction

    function void put_unit16(logic [15:0] u);
      if (pend[10]) begin
        if (u >= 16'hDC00 && u <= 16'hDFFF) begin
          put_code_point(32'h10000 + {pend[9:0], 10'b0} + u[9:0]);
          pend = '0;
          return;
        end
        emit(u2u8_pkg::STAT_UNPAIRED, 8'h00);
        pend = '0;
      end
      if (u == 16'h0000) end_stream();
      else if (u >= 16'hD800 && u <= 16'hDBFF) pend = {1'b1, u[9:0]};
      else if (u >= 16'hDC00 && u <= 16'hDFFF) end_stream();
      else put_code_point({16'h0000, u});
    endfunction

    function void decode_byte(logic [7:0] b);
      logic [31:0] v;
      if (stopped) return;
      case (act_mode)
        u2u8_pkg::MODE_UTF8: begin
          if (b == 8'h00) end_stream();
          else emit(u2u8_pkg::STAT_DATA, b);
        end
        u2u8_pkg::MODE_BYTE: begin
          if (b == 8'h00) end_stream();
          else put_code_point({24'h0, b});
        end
        u2u8_pkg::MODE_U16BE, u2u8_pkg::MODE_U16LE: begin
          held[held_n & 3] = b;
          held_n = (held_n + 1) & 7;
          if (held_n >= 2) begin
            held_n = 0;
            put_unit16((act_mode == u2u8_pkg::MODE_U16BE) ? {held[0], held[1]} :
                                                            {held[1], held[0]});
          end
        end
        default: begin
          held[held_n & 3] = b;
          held_n = (held_n + 1) & 7;
          if (held_n >= 4) begin
            held_n = 0;
            case (act_mode)
              u2u8_pkg::MODE_U4BE:    v = {held[0], held[1], held[2], held[3]};
              u2u8_pkg::MODE_U4LE:    v = {held[3], held[2], held[1], held[0]};
              u2u8_pkg::MODE_U4_2143: v = {held[1], held[0], held[3], held[2]};
              default:                v = {held[2], held[3], held[0], held[1]};
            endcase
            if (v == 32'h0) end_stream();
            else put_code_point(v);
          end
        end
      endcase
    endfunction

    function void sniff_mark(logic [7:0] b);
      logic [7:0]      h [4];
      int              n;
      int              k;
      bit              more;
      bit              found;
      u2u8_pkg::mode_e found_mode;
      logic [15:0]     w;
      logic [15:0]     v;
      k = 0;
      more = 1'b0;
      found = 1'b0;
      found_mode = u2u8_pkg::MODE_UTF8;
      held[held_n & 3] = b;
      held_n = (held_n & 3) + 1;
      n = held_n;
      h = held;
      w = {h[0], h[1]};
      if (n == 1) begin
        more = (b == 8'h00 || b == 8'hFF || b == 8'hFE || b == 8'hEF);
      end else if (n == 2) begin
        more = (w == 16'h0000 || w == 16'hFFFE || w == 16'hFEFF || w == 16'hEFBB);
      end else if (n == 3) begin
        if (w == 16'h0000) begin
          more = (h[2] == 8'hFE || h[2] == 8'hFF);
        end else if (w == 16'hFFFE) begin
          if (h[2] == 8'h00) more = 1'b1;
          else begin found = 1'b1; found_mode = u2u8_pkg::MODE_U16LE; k = 2; end
        end else if (w == 16'hFEFF) begin
          if (h[2] == 8'h00) more = 1'b1;
          else begin found = 1'b1; found_mode = u2u8_pkg::MODE_U16BE; k = 2; end
        end else if (h[2] == 8'hBF) begin
          found = 1'b1; found_mode = u2u8_pkg::MODE_UTF8; k = 3;
        end
      end else begin
        v = {h[2], h[3]};
        if (w == 16'h0000) begin
          if (v == 16'hFEFF) begin
            found = 1'b1; found_mode = u2u8_pkg::MODE_U4BE; k = 4;
          end else if (v == 16'hFFFE) begin
            found = 1'b1; found_mode = u2u8_pkg::MODE_U4_2143; k = 4;
          end
        end else if (w == 16'hFFFE) begin
          found = 1'b1;
          if (h[3] == 8'h00) begin found_mode = u2u8_pkg::MODE_U4LE; k = 4; end
          else begin found_mode = u2u8_pkg::MODE_U16LE; k = 2; end
        end else begin
          found = 1'b1;
          if (h[3] == 8'h00) begin found_mode = u2u8_pkg::MODE_U4_3412; k = 4; end
          else begin found_mode = u2u8_pkg::MODE_U16BE; k = 2; end
        end
      end
      if (more) return;
      held_n = 0;
      sniffing = 1'b0;
      if (found) act_mode = found_mode;
      for (int i = k; i < n && i < 4; i++) decode_byte(h[i]);
    endfunction

    function void take_byte(logic [7:0] b, bit start);
      utf8_res_t r;
      step_toks.delete();
      if (start) begin
        held_n   = 0;
        pend     = '0;
        stopped  = 1'b0;
        act_mode = cfg_mode;
        sniffing = cfg_sniff;
      end
      if (!stopped) begin
        if (sniffing) sniff_mark(b);
        else decode_byte(b);
      end
      foreach (step_toks[i]) begin
        r.tok  = step_toks[i];
        r.last = (i == step_toks.size() - 1);
        utf8_q.push_back(r);
      end
    endfunction

    function void check_out(logic [7:0] data, logic last, logic [1:0] stat);
      utf8_res_t e;
      if (utf8_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output item byte %02h last %0b status %0d",
                 $time, data, last, stat);
        return;
      end
      e = utf8_q.pop_front();
      checked++;
      if (data !== e.tok.data) begin
        errors++;
        $display("%0t: out_byte expected %02h actual %02h", $time, e.tok.data, data);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last);
      end
      if (stat !== e.tok.stat) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.tok.stat, stat);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [7:0]                      in_byte_i;
  logic                            stream_start_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [7:0]                      out_byte_o;
  logic                            last_of_run_o;
  logic [1:0]                      status_o;
  logic                            cfg_we_i;
  logic [u2u8_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [u2u8_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  utf8_predictor pred;
  int            stall_pct = 0;
  int            gap_max = 0;
  int            burst_left = 0;
  int            items_sent = 0;
  int            idle_cycles = 0;

  u2u8_pkg::mode_e phase_mode [NUM_SETTINGS] = '{
    u2u8_pkg::MODE_U16BE, u2u8_pkg::MODE_U16LE, u2u8_pkg::MODE_U4BE,
    u2u8_pkg::MODE_U4LE, u2u8_pkg::MODE_U4_2143, u2u8_pkg::MODE_U4_3412,
    u2u8_pkg::MODE_BYTE, u2u8_pkg::MODE_UTF8, u2u8_pkg::MODE_BYTE,
    u2u8_pkg::MODE_U16LE, u2u8_pkg::MODE_U4_3412, u2u8_pkg::MODE_UTF8};
  bit    phase_sniff [NUM_SETTINGS] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1};

  unicode_to_utf8_transcoder_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .stream_start_i (stream_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pred.check_out(out_byte_o, last_of_run_o, status_o);
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void push_unit16(ref logic [7:0] bq[$], input u2u8_pkg::mode_e m,
                                      input logic [15:0] u);
    if (m == u2u8_pkg::MODE_U16BE) begin
      bq.push_back(u[15:8]);
      bq.push_back(u[7:0]);
    end else begin
      bq.push_back(u[7:0]);
      bq.push_back(u[15:8]);
    end
  endfunction

  function automatic void push_unit32(ref logic [7:0] bq[$], input u2u8_pkg::mode_e m,
                                      input logic [31:0] v);
    case (m)
      u2u8_pkg::MODE_U4BE: begin
        bq.push_back(v[31:24]); bq.push_back(v[23:16]);
        bq.push_back(v[15:8]);  bq.push_back(v[7:0]);
      end
      u2u8_pkg::MODE_U4LE: begin
        bq.push_back(v[7:0]);   bq.push_back(v[15:8]);
        bq.push_back(v[23:16]); bq.push_back(v[31:24]);
      end
      u2u8_pkg::MODE_U4_2143: begin
        bq.push_back(v[23:16]); bq.push_back(v[31:24]);
        bq.push_back(v[7:0]);   bq.push_back(v[15:8]);
      end
      default: begin
        bq.push_back(v[15:8]);  bq.push_back(v[7:0]);
        bq.push_back(v[31:24]); bq.push_back(v[23:16]);
      end
    endcase
  endfunction

  // Build one stream: optional mark, code points in the stream's encoding, optional
  // terminator and trailing bytes. Returns the number of bytes before the trailing bytes.
  function automatic int build_stream(ref logic [7:0] bq[$], input u2u8_pkg::mode_e cfg,
                                      input bit sniff);
    u2u8_pkg::mode_e m;
    int              kind;
    int              body;
    logic [31:0]     cp;
    m = cfg;
    bq.delete();
    if (sniff) begin
      case ($urandom_range(0, 9))
        0: begin bq = '{8'h00, 8'h00, 8'hFE, 8'hFF}; m = u2u8_pkg::MODE_U4BE; end
        1: begin bq = '{8'h00, 8'h00, 8'hFF, 8'hFE}; m = u2u8_pkg::MODE_U4_2143; end
        2: begin bq = '{8'hFF, 8'hFE, 8'h00, 8'h00}; m = u2u8_pkg::MODE_U4LE; end
        3: begin bq = '{8'hFE, 8'hFF, 8'h00, 8'h00}; m = u2u8_pkg::MODE_U4_3412; end
        4: begin bq = '{8'hFF, 8'hFE}; m = u2u8_pkg::MODE_U16LE; end
        5: begin bq = '{8'hFE, 8'hFF}; m = u2u8_pkg::MODE_U16BE; end
        6: begin bq = '{8'hEF, 8'hBB, 8'hBF}; m = u2u8_pkg::MODE_UTF8; end
        default: ;
      endcase
    end
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(0, 15);
      if (kind < 6) cp = $urandom_range(1, 32'h7F);
      else if (kind < 8) cp = $urandom_range(32'h80, 32'h7FF);
      else if (kind < 10) cp = $urandom_range(32'h800, 32'hFFFF);
      else if (kind < 12) cp = $urandom_range(32'h10000, 32'h10FFFF);
      else if (kind < 13) cp = $urandom_range(32'h110000, 32'h7FFFFFFF);
      else if (kind < 14) cp = $urandom() | 32'h80000000;
      else cp = $urandom_range(32'hD800, 32'hDFFF);
      case (m)
        u2u8_pkg::MODE_UTF8, u2u8_pkg::MODE_BYTE: bq.push_back(8'($urandom_range(1, 255)));
        u2u8_pkg::MODE_U16BE, u2u8_pkg::MODE_U16LE: begin
          if (cp < 32'h10000) begin
            push_unit16(bq, m, cp[15:0]);
          end else begin
            cp = (cp & 32'hFFFFF);
            push_unit16(bq, m, 16'hD800 | 16'(cp >> 10));
            push_unit16(bq, m, 16'hDC00 | 16'(cp & 32'h3FF));
          end
        end
        default: push_unit32(bq, m, cp);
      endcase
    end
    if ($urandom_range(0, 7) == 0) bq.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 1) begin
      case (m)
        u2u8_pkg::MODE_UTF8, u2u8_pkg::MODE_BYTE:   bq.push_back(8'h00);
        u2u8_pkg::MODE_U16BE, u2u8_pkg::MODE_U16LE: push_unit16(bq, m, 16'h0000);
        default:                                    push_unit32(bq, m, 32'h0);
      endcase
      body = bq.size();
      repeat ($urandom_range(0, 2)) bq.push_back(8'($urandom_range(0, 255)));
    end else begin
      body = bq.size();
    end
    return body;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit start);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid_i     = 1'b1;
    in_byte_i      = b;
    stream_start_i = start;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    pred.take_byte(b, start);
    items_sent++;
  endtask

  task automatic send_stream(ref logic [7:0] bq[$]);
    foreach (bq[i]) send_byte(bq[i], i == 0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (pred.utf8_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [u2u8_pkg::CFG_IDX_W-1:0] idx,
                           input logic [u2u8_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(posedge clk);
    pred.set_reg(idx, val);
  endtask

  initial begin
    logic [7:0] bq[$];
    int         phase_bytes;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    stream_start_i = 1'b0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = u2u8_pkg::CFG_MODE;
    cfg_wdata_i    = '0;
    pred = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset state before any stream start: UTF-8 with mark detection
    stall_pct = 30;
    gap_max   = 2;
    send_byte(8'hC3, 1'b0);
    // UTF-16BE mark, surrogate pair, unpaired high, end of string, ignored byte
    bq = '{8'hFE, 8'hFF, 8'hD8, 8'h3D, 8'hDC, 8'h00, 8'hD8, 8'h00, 8'h00, 8'h41,
           8'h00, 8'h00, 8'h41};
    send_stream(bq);
    // UCS-4LE mark, code point above range dropped, largest code point
    bq = '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
           8'hFF, 8'h7F};
    send_stream(bq);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      cfg_write(u2u8_pkg::CFG_MODE, phase_mode[p]);
      cfg_write(u2u8_pkg::CFG_SNIFF, {{(u2u8_pkg::CFG_DATA_W-1){1'b0}}, phase_sniff[p]});
      @(negedge clk);
      cfg_we_i  = 1'b0;
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(10, 80);
      gap_max   = (p % 3 == 0) ? 0 : $urandom_range(2, 10);
      phase_bytes = 0;
      while (phase_bytes < PHASE_ITEMS) begin
        phase_bytes += build_stream(bq, phase_mode[p], phase_sniff[p]);
        send_stream(bq);
      end
    end

    @(negedge clk);
    in_valid_i = 1'b0;
    while (pred.utf8_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("summary: %0d input items over %0d mode settings", items_sent, NUM_SETTINGS + 1);
    $display("summary: %0d output items checked, %0d mismatches", pred.checked, pred.errors);
    if (pred.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
